/* src/rbst_pkg.sv */
// Package for the repeat body suppression table: sizes, item kinds, records
// and the command/status structs between controller and datapath.
// No dependencies.
package rbst_pkg;

  localparam int CONNECTIONS   = 64;
  localparam int BODY_CAPACITY = 16 * 1024;
  localparam int SLOTS         = CONNECTIONS * 2;
  localparam int CONN_W        = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam int SLOT_W        = CONN_W + 1;
  localparam int OFF_W         = $clog2(BODY_CAPACITY);
  localparam int BODY_AW       = SLOT_W + 1 + OFF_W;
  localparam int BODY_DEPTH    = SLOTS * 2 * BODY_CAPACITY;

  typedef enum logic [2:0] {
    K_COMPARE = 3'd0,
    K_STAGE   = 3'd1,
    K_COMMIT  = 3'd2,
    K_DISCARD = 3'd3,
    K_ADOPT   = 3'd4,
    K_DEFER   = 3'd5
  } kind_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  connection;
    logic        channel;
    logic [63:0] binding_generation;
    logic [7:0]  body_byte;
    logic        body_empty;
    logic        last;
    logic [63:0] host_revision;
    logic [63:0] scriptable_revision;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic        repeated;
    logic        delta_found;
    logic [14:0] first_diff_offset;
    logic [7:0]  old_byte;
    logic [7:0]  new_byte;
    logic [14:0] previous_length;
    logic [15:0] current_length;
    logic        report_deferral;
  } result_t;

  typedef struct packed {
    logic [63:0] sent_gen;
    logic [14:0] sent_len;
    logic [63:0] staged_gen;
    logic [14:0] staged_len;
  } record_t;

  typedef struct packed {
    logic [63:0] gen;
    logic [63:0] host;
    logic [63:0] script;
  } triple_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic exec;
    logic tail;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic need_tail;
  } status_t;

endpackage

/* src/rbst_ctrl.sv */
// Sequencer for the repeat body suppression table: load, fetch, execute and
// compare tail steps. Depends on rbst_pkg.
module rbst_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rbst_pkg::status_t status,
  output rbst_pkg::cmd_t  cmd
);
  import rbst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_EXEC  = 4'b0100,
    S_TAIL  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = status.out_free;
        if (status.out_free) state_next = status.need_tail ? S_TAIL : S_IDLE;
      end
      S_TAIL: begin
        cmd.tail   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* src/rbst_datapath.sv */
// Datapath: body memory, per-slot record memory, deferral memory, pass
// registers and the result register. Depends on rbst_pkg.
module rbst_datapath (
  input  logic              clk,
  input  logic              rst,
  input  rbst_pkg::cmd_t    cmd,
  output rbst_pkg::status_t status,
  input  rbst_pkg::item_t   item_in,
  output rbst_pkg::result_t result,
  output logic              result_valid,
  input  logic              result_ready
);
  import rbst_pkg::*;

  localparam logic [16:0] CAP = 17'(BODY_CAPACITY);

  item_t   itm;
  logic [7:0]  body_mem [BODY_DEPTH];
  logic [7:0]  body_q;
  record_t rec_mem [SLOTS];
  record_t rec_q;
  logic    rec_ok;
  triple_t def_mem [CONNECTIONS];
  triple_t def_q;
  logic    def_ok;
  logic [SLOTS-1:0]       rec_written, live_sel, sent_valid, staged_valid;
  logic [CONNECTIONS-1:0] def_written;

  logic [15:0] byte_offset;
  logic        diff_found;
  logic [14:0] diff_offset;
  logic [7:0]  diff_old, diff_new;
  logic        stage_overflow;

  result_t res;
  logic    res_valid;

  logic              in_range, active, lsel, valid_gen, same, gen_match;
  logic [SLOT_W-1:0] slot;
  logic [CONN_W-1:0] cidx;
  record_t           rec, rec_w;
  triple_t           defv, trip;
  logic              rec_we, def_we;
  logic [15:0]       plen16, off_adv;
  logic              off_in_cap, cur_in;
  logic              c_found;
  logic [14:0]       c_off;
  logic [7:0]        c_old, c_new;
  logic              s_ovf, stv_w, sv_w, flip;
  logic [BODY_AW-1:0] fetch_addr, wr_addr, tail_addr;
  logic              body_we;
  logic              t_found, rep;
  logic [14:0]       t_off;
  logic [7:0]        t_old, t_new;
  result_t           res_w;
  logic              res_load;

  assign in_range   = {1'b0, itm.connection} < 9'(CONNECTIONS);
  assign slot       = {itm.connection[CONN_W-1:0], itm.channel};
  assign cidx       = itm.connection[CONN_W-1:0];
  assign rec        = rec_ok ? rec_q : '0;
  assign defv       = def_ok ? def_q : '0;
  assign trip       = '{gen: itm.binding_generation, host: itm.host_revision,
                        script: itm.scriptable_revision};
  assign same       = in_range && (defv == trip);
  assign lsel       = live_sel[slot];
  assign plen16     = {1'b0, rec.sent_len};
  assign off_in_cap = {1'b0, byte_offset} < CAP;
  assign off_adv    = itm.body_empty ? byte_offset :
                      (byte_offset != 16'hFFFF) ? byte_offset + 16'd1 : byte_offset;
  assign active     = in_range && !(itm.body_empty && !itm.last);
  assign gen_match  = rec.staged_gen == itm.binding_generation;
  assign valid_gen  = sent_valid[slot] && (rec.sent_gen == itm.binding_generation);

  assign fetch_addr = {slot, (itm.kind == K_STAGE) ? ~lsel : lsel,
                       byte_offset[OFF_W-1:0]};
  assign wr_addr    = {slot, ~lsel, byte_offset[OFF_W-1:0]};
  assign tail_addr  = {slot, lsel, off_adv[OFF_W-1:0]};

  assign status.need_tail = (itm.kind == K_COMPARE) && in_range && itm.last;
  assign status.out_free  = !res_valid || result_ready;

  // compare step on the current byte
  always_comb begin
    c_found = diff_found;
    c_off   = diff_offset;
    c_old   = diff_old;
    c_new   = diff_new;
    if (!itm.body_empty && !diff_found) begin
      if (byte_offset < plen16 && off_in_cap) begin
        if (body_q != itm.body_byte) begin
          c_found = 1'b1;
          c_off   = byte_offset[14:0];
          c_old   = body_q;
          c_new   = itm.body_byte;
        end
      end else if (byte_offset == plen16) begin
        c_found = 1'b1;
        c_off   = byte_offset[14:0];
        c_old   = 8'd0;
        c_new   = itm.body_byte;
      end
    end
  end

  // record updates for stage, commit, discard and adopt
  always_comb begin
    rec_w  = rec;
    rec_we = 1'b0;
    stv_w  = staged_valid[slot];
    sv_w   = sent_valid[slot];
    flip   = 1'b0;
    s_ovf  = stage_overflow | (!itm.body_empty && !off_in_cap);
    body_we = 1'b0;
    if (in_range) begin
      case (itm.kind)
        K_COMMIT: begin
          rec_we = 1'b1;
          if (staged_valid[slot] && gen_match) begin
            flip = 1'b1;
            sv_w = 1'b1;
            rec_w.sent_gen = rec.staged_gen;
            rec_w.sent_len = rec.staged_len;
          end
          stv_w = 1'b0;
        end
        K_DISCARD: begin
          rec_we = 1'b1;
          stv_w  = 1'b0;
          if (itm.channel) begin
            rec_w.staged_gen = '0;
            rec_w.staged_len = '0;
          end
        end
        K_ADOPT: begin
          if (itm.channel && staged_valid[slot]) begin
            rec_we = 1'b1;
            flip   = 1'b1;
            sv_w   = 1'b1;
            stv_w  = 1'b0;
            rec_w.staged_gen = itm.binding_generation;
            rec_w.sent_gen   = itm.binding_generation;
            rec_w.sent_len   = rec.staged_len;
          end
        end
        K_STAGE: begin
          if (active) begin
            rec_we  = 1'b1;
            stv_w   = 1'b0;
            body_we = !itm.body_empty && off_in_cap;
            if (itm.last && !s_ovf) begin
              stv_w = 1'b1;
              rec_w.staged_gen = itm.binding_generation;
              rec_w.staged_len = off_adv[14:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // compare tail: compared body shorter than the delivered one
  always_comb begin
    cur_in  = (byte_offset < plen16) && off_in_cap;
    t_found = diff_found;
    t_off   = diff_offset;
    t_old   = diff_old;
    t_new   = diff_new;
    if (!diff_found && cur_in) begin
      t_found = 1'b1;
      t_off   = byte_offset[14:0];
      t_old   = body_q;
      t_new   = 8'd0;
    end
    rep = valid_gen && !t_found && (byte_offset == plen16);
  end

  assign def_we = cmd.exec && (itm.kind == K_DEFER) && in_range && !same;

  always_comb begin
    res_w    = '0;
    res_load = 1'b0;
    if (cmd.exec && itm.kind == K_DEFER) begin
      res_load              = 1'b1;
      res_w.result_kind     = 1'b1;
      res_w.report_deferral = !same;
    end else if (cmd.tail) begin
      res_load             = 1'b1;
      res_w.repeated       = rep;
      res_w.current_length = byte_offset;
      if (valid_gen) begin
        res_w.previous_length = rec.sent_len;
        if (!rep) begin
          res_w.delta_found       = 1'b1;
          res_w.first_diff_offset = t_off;
          res_w.old_byte          = t_old;
          res_w.new_byte          = t_new;
        end
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.load) itm <= item_in;
    if (cmd.fetch) begin
      body_q <= body_mem[fetch_addr];
      rec_q  <= rec_mem[slot];
      def_q  <= def_mem[cidx];
    end else if (cmd.exec && status.need_tail) begin
      body_q <= body_mem[tail_addr];
    end
    if (cmd.exec && body_we) body_mem[wr_addr] <= itm.body_byte;
    if (cmd.exec && rec_we)  rec_mem[slot] <= rec_w;
    if (def_we)              def_mem[cidx] <= trip;
    if (res_load)            res <= res_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_ok         <= 1'b0;
      def_ok         <= 1'b0;
      rec_written    <= '0;
      def_written    <= '0;
      live_sel       <= '0;
      sent_valid     <= '0;
      staged_valid   <= '0;
      byte_offset    <= '0;
      diff_found     <= 1'b0;
      diff_offset    <= '0;
      diff_old       <= '0;
      diff_new       <= '0;
      stage_overflow <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (cmd.fetch) begin
        rec_ok <= rec_written[slot];
        def_ok <= def_written[cidx];
      end
      if (cmd.exec && rec_we) begin
        rec_written[slot]  <= 1'b1;
        staged_valid[slot] <= stv_w;
        sent_valid[slot]   <= sv_w;
        if (flip) live_sel[slot] <= ~lsel;
      end
      if (def_we) def_written[cidx] <= 1'b1;
      if (cmd.exec && active && itm.kind == K_STAGE) begin
        if (itm.last) begin
          byte_offset    <= '0;
          diff_found     <= 1'b0;
          diff_offset    <= '0;
          diff_old       <= '0;
          diff_new       <= '0;
          stage_overflow <= 1'b0;
        end else begin
          byte_offset    <= off_adv;
          stage_overflow <= s_ovf;
        end
      end
      if (cmd.exec && active && itm.kind == K_COMPARE) begin
        byte_offset <= off_adv;
        diff_found  <= c_found;
        diff_offset <= c_off;
        diff_old    <= c_old;
        diff_new    <= c_new;
      end
      if (cmd.tail) begin
        byte_offset    <= '0;
        diff_found     <= 1'b0;
        diff_offset    <= '0;
        diff_old       <= '0;
        diff_new       <= '0;
        stage_overflow <= 1'b0;
      end
      if (res_load)          res_valid <= 1'b1;
      else if (result_ready) res_valid <= 1'b0;
    end
  end

  assign result       = res;
  assign result_valid = res_valid;

endmodule

/* src/repeat_body_suppression_table_unit.sv */
// Repeat body suppression table: top level, stream packing of items and
// results around rbst_ctrl and rbst_datapath. Depends on rbst_pkg.
//
// Input channel s_*: one item per handshake. tuser carries the item kind,
// tlast ends a body pass, tdata the remaining fields. Body bytes of a pass
// stream in order; a compare pass on a connection in range gives one result
// after its last item, a deferral check gives one result, other kinds none.
// Output channel m_*: tuser is the result kind, tdata the result fields.
// Steps: an item passes from acceptance through load, memory fetch and
// execute; the last item of a compare pass adds a tail step, which needs a
// second read on the single port of the body memory. A result appears in the
// output register in the cycle after the execute or tail step that made it.
// When the receiver stalls, the next item is still taken and fetched; it
// holds in its execute step only while the output register is full.
// Reset clears all records, valid marks and the pass state; no clearing
// pass is needed and the block is ready in the cycle after reset.
module repeat_body_suppression_table_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // connection, channel, binding_generation, body_byte, body_empty,
  // host_revision, scriptable_revision
  input  logic [215:0] s_tdata,
  // kind
  input  logic [2:0]   s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // repeated, delta_found, first_diff_offset, old_byte, new_byte,
  // previous_length, current_length, report_deferral
  output logic [71:0]  m_tdata,
  // result_kind
  output logic [0:0]   m_tuser
);
  import rbst_pkg::*;

  cmd_t    cmd;
  status_t status;
  item_t   item;
  result_t res;

  always_comb begin
    item.kind                = s_tuser;
    item.connection          = s_tdata[7:0];
    item.channel             = s_tdata[8];
    item.binding_generation  = s_tdata[72:9];
    item.body_byte           = s_tdata[80:73];
    item.body_empty          = s_tdata[81];
    item.host_revision       = s_tdata[145:82];
    item.scriptable_revision = s_tdata[209:146];
    item.last                = s_tlast;
  end

  rbst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rbst_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item_in      (item),
    .result       (res),
    .result_valid (m_tvalid),
    .result_ready (m_tready)
  );

  assign m_tuser = res.result_kind;
  assign m_tdata = {7'd0, res.report_deferral, res.current_length,
                    res.previous_length, res.new_byte, res.old_byte,
                    res.first_diff_offset, res.delta_found, res.repeated};

endmodule
